FILE: src/tsa_pkg.sv
// Package for the time span arithmetic unit: word types, stage records,
// normalization constants and the seconds-of-day helper. No dependencies.
`default_nettype none

package tsa_pkg;

   // Day range used for saturation; the ports always carry 32-bit days.
   localparam int DAY_BITS = 32;
   localparam int LIM_BITS = (DAY_BITS < 32) ? DAY_BITS : 32;

   // Time unit constants.
   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_DAY  = 86400;

   // Internal widths.
   localparam int SOD_W  = 17;          // seconds of day, up to 31:63:63
   localparam int OPD_W  = 33;          // signed seconds operand
   localparam int SUM_W  = 33;          // biased seconds sum, never negative
   localparam int XS_W   = SUM_W + 1;   // signed width for the biased sum
   localparam int DSUM_W = 33;          // sum or difference of two days
   localparam int DAYF_W = 35;          // day after carry, before saturation
   localparam int Q_W    = 17;          // day quotient of the biased sum
   localparam int R0_W   = 18;          // remainder before its correction
   localparam int HOUR_W = 5;
   localparam int MIN_W  = 6;
   localparam int SEC_W  = 6;
   localparam int TM_W   = 11;          // total minutes of a day

   // The biased sum is always non-negative, which makes floor division plain.
   localparam int DAY_BIAS = 24857;
   localparam logic [XS_W-1:0] SOD_BIAS = XS_W'(64'(DAY_BIAS) * 64'(SECS_PER_DAY));

   // Division by 86400 is a shift by 7 and a reciprocal multiply by 1/675.
   localparam int DIV_PRE_SHIFT = 7;
   localparam int RECIP_SHIFT   = 36;
   localparam int RECIP_W       = 27;
   localparam int Y_W           = SUM_W - DIV_PRE_SHIFT;
   localparam int DP_W          = Y_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_DAY =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SECS_PER_DAY >> DIV_PRE_SHIFT));

   // Exact reciprocals for hours (shift 4, then 1/225) and minutes (shift 2, then 1/15).
   localparam int HOUR_PRE   = 4;
   localparam int HOUR_SHIFT = 20;
   localparam int HOUR_RECIP = 4661;
   localparam int HP_W       = 26;
   localparam int MIN_PRE    = 2;
   localparam int MIN_SHIFT  = 19;
   localparam int MIN_RECIP  = 34953;
   localparam int MP_W       = 31;

   // Saturation limits of the result day.
   localparam logic signed [DAYF_W-1:0] DAY_MAX =
      (DAYF_W'(1) <<< (LIM_BITS - 1)) - DAYF_W'(1);
   localparam logic signed [DAYF_W-1:0] DAY_MIN = ~DAY_MAX;

   // Operation codes.
   typedef enum logic [2:0] {
      FUNC_ADD_SPAN = 3'd0,
      FUNC_SUB_SPAN = 3'd1,
      FUNC_ADD_SEC  = 3'd2,
      FUNC_SUB_SEC  = 3'd3,
      FUNC_COMPARE  = 3'd4
   } func_type;

   // Input word.
   typedef struct packed {
      logic        [2:0]  func;
      logic signed [31:0] a_day;
      logic        [4:0]  a_hour;
      logic        [5:0]  a_minute;
      logic        [5:0]  a_second;
      logic signed [31:0] b_day;
      logic        [4:0]  b_hour;
      logic        [5:0]  b_minute;
      logic        [5:0]  b_second;
      logic signed [31:0] delta_seconds;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic signed [31:0] res_day;
      logic        [4:0]  res_hour;
      logic        [5:0]  res_minute;
      logic        [5:0]  res_second;
      logic               is_equal;
      logic               is_greater;
      logic               is_less;
      logic               overflow;
   } rsp_word_type;

   // Operation class that travels down the pipeline.
   typedef struct packed {
      logic arith;
      logic cmp;
      logic sub;
   } op_ctl_type;

   // Front end to divider: day sum and biased seconds sum.
   typedef struct packed {
      op_ctl_type               ctl;
      logic signed [DSUM_W-1:0] day_sum;
      logic        [SUM_W-1:0]  x;
   } sum_type;

   // Divider to splitter: carried day and seconds of day.
   typedef struct packed {
      op_ctl_type               ctl;
      logic signed [DAYF_W-1:0] day_full;
      logic        [SOD_W-1:0]  rem;
   } norm_type;

   // Seconds of day of hours, minutes and seconds as given.
   function automatic logic [SOD_W-1:0] span_sod(input logic [4:0] h,
                                                 input logic [5:0] m,
                                                 input logic [5:0] s);
      logic [SOD_W-1:0] acc;
      acc = SOD_W'(h) * SOD_W'(SECS_PER_HOUR) + SOD_W'(m) * SOD_W'(SECS_PER_MIN)
          + SOD_W'(s);
      return acc;
   endfunction

endpackage

`default_nettype wire

FILE: src/time_span_arithmetic_unit.sv
// Channel   Direction  Word type      Handshake
// req_      in         req_word_type  req_valid / req_stall
// rsp_      out        rsp_word_type  rsp_valid / rsp_stall
//
// Eight register stages: two in the front end, three in the floor divider by
// 86400, three in the back end; one word enters per cycle while the first stage
// is not held. Reset clears only the stage valid bits. A stall holds a stage only
// while it is full, so empty stages still take words during a stall.
// Top level of the time span unit. Depends on tsa_pkg, tsa_front, tsa_divider
// and tsa_split.
`default_nettype none

module time_span_arithmetic_unit import tsa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic     sum_valid, sum_stall;
   sum_type  sum_word;
   logic     norm_valid, norm_stall;
   norm_type norm_word;

   // Operand selection and adders.
   tsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (sum_valid),
      .out_stall (sum_stall),
      .out_word  (sum_word)
   );

   // Floor division into days and seconds of day.
   tsa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_stall  (sum_stall),
      .in_word   (sum_word),
      .out_valid (norm_valid),
      .out_stall (norm_stall),
      .out_word  (norm_word)
   );

   // Saturation, flags and hour, minute, second split.
   tsa_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_stall  (norm_stall),
      .in_word   (norm_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

`default_nettype wire

FILE: src/tsa_front.sv
// Front end of the time span unit: operand selection and the two adders.
// Depends on tsa_pkg.
`default_nettype none

module tsa_front import tsa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire req_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_stall,
   output sum_type           out_word
);

   typedef struct packed {
      op_ctl_type              ctl;
      logic signed [31:0]      a_day;
      logic signed [31:0]      opd_day;
      logic        [SOD_W-1:0] a_sod;
      logic signed [OPD_W-1:0] opd_sod;
   } opnd_type;

   opnd_type s1_in, s1_ff;
   sum_type  s2_in, s2_ff;
   logic     s1_valid_ff, s2_valid_ff;
   logic     hold1, hold2;

   logic signed [XS_W-1:0] sod_a, sod_o, xs;

   // A stage holds only when it is full and the stage after it holds.
   assign hold2    = s2_valid_ff && out_stall;
   assign hold1    = s1_valid_ff && hold2;
   assign in_stall = hold1;

   // Stage 1: seconds of day of both spans and choice of the second operand.
   always_comb begin
      s1_in.ctl.arith = in_word.func inside {FUNC_ADD_SPAN, FUNC_SUB_SPAN,
                                             FUNC_ADD_SEC, FUNC_SUB_SEC};
      s1_in.ctl.cmp   = (in_word.func == FUNC_COMPARE);
      s1_in.ctl.sub   = in_word.func inside {FUNC_SUB_SPAN, FUNC_SUB_SEC, FUNC_COMPARE};
      s1_in.a_day     = in_word.a_day;
      s1_in.a_sod     = span_sod(in_word.a_hour, in_word.a_minute, in_word.a_second);
      if (in_word.func inside {FUNC_ADD_SEC, FUNC_SUB_SEC}) begin
         s1_in.opd_day = '0;
         s1_in.opd_sod = OPD_W'(in_word.delta_seconds);
      end else begin
         s1_in.opd_day = in_word.b_day;
         s1_in.opd_sod = $signed(OPD_W'(span_sod(in_word.b_hour, in_word.b_minute,
                                                 in_word.b_second)));
      end
   end

   // Stage 2: day sum and biased seconds sum.
   always_comb begin
      sod_a = $signed(XS_W'(s1_ff.a_sod));
      sod_o = XS_W'(s1_ff.opd_sod);
      s2_in.ctl = s1_ff.ctl;
      if (s1_ff.ctl.sub) begin
         s2_in.day_sum = DSUM_W'(s1_ff.a_day) - DSUM_W'(s1_ff.opd_day);
         xs            = sod_a - sod_o + $signed(SOD_BIAS);
      end else begin
         s2_in.day_sum = DSUM_W'(s1_ff.a_day) + DSUM_W'(s1_ff.opd_day);
         xs            = sod_a + sod_o + $signed(SOD_BIAS);
      end
      s2_in.x = xs[SUM_W-1:0];
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (!hold1) s1_valid_ff <= in_valid;
         if (!hold2) s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (!hold1 && in_valid) s1_ff <= s1_in;
      if (!hold2 && s1_valid_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_ff;

endmodule

`default_nettype wire

FILE: src/tsa_divider.sv
// Floor division of the biased seconds sum by 86400 over three stages:
// reciprocal estimate, remainder, correction and day carry. Depends on tsa_pkg.
`default_nettype none

module tsa_divider import tsa_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire sum_type in_word,
   output logic         out_valid,
   input  wire logic    out_stall,
   output norm_type     out_word
);

   typedef struct packed {
      op_ctl_type               ctl;
      logic signed [DSUM_W-1:0] day_sum;
      logic        [SUM_W-1:0]  x;
      logic        [Q_W-1:0]    q_est;
   } est_type;

   typedef struct packed {
      op_ctl_type               ctl;
      logic signed [DSUM_W-1:0] day_sum;
      logic        [Q_W-1:0]    q_est;
      logic        [R0_W-1:0]   r0;
   } rem_type;

   est_type  s3_in, s3_ff;
   rem_type  s4_in, s4_ff;
   norm_type s5_in, s5_ff;
   logic     s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic     hold3, hold4, hold5;

   logic [DP_W-1:0]  dprod;
   logic [SUM_W-1:0] r0_full;
   logic [Q_W-1:0]   q_fix;

   assign hold5    = s5_valid_ff && out_stall;
   assign hold4    = s4_valid_ff && hold5;
   assign hold3    = s3_valid_ff && hold4;
   assign in_stall = hold3;

   // Stage 3: quotient estimate, equal to the true quotient or one below.
   always_comb begin
      dprod         = DP_W'(in_word.x[SUM_W-1:DIV_PRE_SHIFT]) * DP_W'(RECIP_DAY);
      s3_in.ctl     = in_word.ctl;
      s3_in.day_sum = in_word.day_sum;
      s3_in.x       = in_word.x;
      s3_in.q_est   = dprod[RECIP_SHIFT +: Q_W];
   end

   // Stage 4: remainder of the estimate, below twice a day.
   always_comb begin
      r0_full       = s3_ff.x - SUM_W'(s3_ff.q_est) * SUM_W'(SECS_PER_DAY);
      s4_in.ctl     = s3_ff.ctl;
      s4_in.day_sum = s3_ff.day_sum;
      s4_in.q_est   = s3_ff.q_est;
      s4_in.r0      = r0_full[R0_W-1:0];
   end

   // Stage 5: one correction step, then carry the quotient into the day.
   always_comb begin
      s5_in.ctl = s4_ff.ctl;
      if (s4_ff.r0 >= R0_W'(SECS_PER_DAY)) begin
         q_fix     = s4_ff.q_est + Q_W'(1);
         s5_in.rem = SOD_W'(s4_ff.r0 - R0_W'(SECS_PER_DAY));
      end else begin
         q_fix     = s4_ff.q_est;
         s5_in.rem = s4_ff.r0[SOD_W-1:0];
      end
      s5_in.day_full = DAYF_W'(s4_ff.day_sum) + $signed(DAYF_W'(q_fix))
                     - DAYF_W'(DAY_BIAS);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (!hold3) s3_valid_ff <= in_valid;
         if (!hold4) s4_valid_ff <= s3_valid_ff;
         if (!hold5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (!hold3 && in_valid) s3_ff <= s3_in;
      if (!hold4 && s3_valid_ff) s4_ff <= s4_in;
      if (!hold5 && s4_valid_ff) s5_ff <= s5_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_word  = s5_ff;

`ifndef SYNTHESIS
   // The estimate is never more than one below the quotient.
   a_r0_range: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_ff.r0 < R0_W'(2 * SECS_PER_DAY)))
      else $error("divider remainder estimate out of range");

   // After correction the remainder is a proper seconds of day.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (s5_ff.rem < SOD_W'(SECS_PER_DAY)))
      else $error("divider remainder not below one day");
`endif

endmodule

`default_nettype wire

FILE: src/tsa_split.sv
// Back end of the time span unit: saturation, compare flags and the split of
// seconds of day into hours, minutes and seconds. Depends on tsa_pkg.
`default_nettype none

module tsa_split import tsa_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire norm_type in_word,
   output logic          out_valid,
   input  wire logic     out_stall,
   output rsp_word_type  out_word
);

   typedef struct packed {
      logic signed [31:0]      day;
      logic        [SOD_W-1:0] rem;
      logic                    ovf;
      logic                    eq;
      logic                    gt;
      logic                    lt;
   } sat_type;

   typedef struct packed {
      logic signed [31:0]       day;
      logic        [SOD_W-1:0]  rem;
      logic        [HOUR_W-1:0] hour;
      logic        [TM_W-1:0]   tm;
      logic                     ovf;
      logic                     eq;
      logic                     gt;
      logic                     lt;
   } hms_type;

   sat_type      s6_in, s6_ff;
   hms_type      s7_in, s7_ff;
   rsp_word_type s8_in, s8_ff;
   logic         s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic         hold6, hold7, hold8;

   logic [HP_W-1:0]  hprod;
   logic [MP_W-1:0]  mprod;
   logic [TM_W-1:0]  m_full;
   logic [SOD_W-1:0] s_full;

   assign hold8    = s8_valid_ff && out_stall;
   assign hold7    = s7_valid_ff && hold8;
   assign hold6    = s6_valid_ff && hold7;
   assign in_stall = hold6;

   // Stage 6: saturate arithmetic results; a compare reads the sign of A minus B.
   always_comb begin
      s6_in = '0;
      if (in_word.ctl.arith) begin
         if (in_word.day_full > DAY_MAX) begin
            s6_in.day = 32'(DAY_MAX);
            s6_in.rem = SOD_W'(SECS_PER_DAY - 1);
            s6_in.ovf = 1'b1;
         end else if (in_word.day_full < DAY_MIN) begin
            s6_in.day = 32'(DAY_MIN);
            s6_in.rem = '0;
            s6_in.ovf = 1'b1;
         end else begin
            s6_in.day = in_word.day_full[31:0];
            s6_in.rem = in_word.rem;
         end
      end else if (in_word.ctl.cmp) begin
         s6_in.eq = (in_word.day_full == '0) && (in_word.rem == '0);
         s6_in.lt = in_word.day_full[DAYF_W-1];
         s6_in.gt = !in_word.day_full[DAYF_W-1] && !s6_in.eq;
      end
   end

   // Stage 7: hours and total minutes by exact reciprocal multiplies.
   always_comb begin
      hprod      = HP_W'(s6_ff.rem[SOD_W-1:HOUR_PRE]) * HP_W'(HOUR_RECIP);
      mprod      = MP_W'(s6_ff.rem[SOD_W-1:MIN_PRE]) * MP_W'(MIN_RECIP);
      s7_in.day  = s6_ff.day;
      s7_in.rem  = s6_ff.rem;
      s7_in.hour = hprod[HOUR_SHIFT +: HOUR_W];
      s7_in.tm   = mprod[MIN_SHIFT +: TM_W];
      s7_in.ovf  = s6_ff.ovf;
      s7_in.eq   = s6_ff.eq;
      s7_in.gt   = s6_ff.gt;
      s7_in.lt   = s6_ff.lt;
   end

   // Stage 8: minutes within the hour and seconds within the minute.
   always_comb begin
      m_full           = s7_ff.tm - TM_W'(s7_ff.hour) * TM_W'(MINS_PER_HOUR);
      s_full           = s7_ff.rem - SOD_W'(s7_ff.tm) * SOD_W'(SECS_PER_MIN);
      s8_in.res_day    = s7_ff.day;
      s8_in.res_hour   = s7_ff.hour;
      s8_in.res_minute = m_full[MIN_W-1:0];
      s8_in.res_second = s_full[SEC_W-1:0];
      s8_in.is_equal   = s7_ff.eq;
      s8_in.is_greater = s7_ff.gt;
      s8_in.is_less    = s7_ff.lt;
      s8_in.overflow   = s7_ff.ovf;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         if (!hold6) s6_valid_ff <= in_valid;
         if (!hold7) s7_valid_ff <= s6_valid_ff;
         if (!hold8) s8_valid_ff <= s7_valid_ff;
      end
   end

   // Stage registers; stage 8 is the output register.
   always_ff @(posedge clock) begin
      if (!hold6 && in_valid) s6_ff <= s6_in;
      if (!hold7 && s6_valid_ff) s7_ff <= s7_in;
      if (!hold8 && s7_valid_ff) s8_ff <= s8_in;
   end

   assign out_valid = s8_valid_ff;
   assign out_word  = s8_ff;

`ifndef SYNTHESIS
   // At most one compare flag is ever raised.
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      s8_valid_ff |-> $onehot0({s8_ff.is_equal, s8_ff.is_greater, s8_ff.is_less}))
      else $error("more than one compare flag set");

   // Overflow and compare flags never come together.
   a_ovf_no_flags: assert property (@(posedge clock) disable iff (reset)
      (s8_valid_ff && s8_ff.overflow) |->
         !(s8_ff.is_equal || s8_ff.is_greater || s8_ff.is_less))
      else $error("overflow raised on a compare");

   // The split always gives a normalized time of day.
   a_hms_range: assert property (@(posedge clock) disable iff (reset)
      s8_valid_ff |-> (s8_ff.res_hour < HOUR_W'(24) && s8_ff.res_minute < MIN_W'(60)
                       && s8_ff.res_second < SEC_W'(60)))
      else $error("result time of day not normalized");
`endif

endmodule

`default_nettype wire

FILE: tb/time_span_arithmetic_unit_checker.sv
// Checker for the time span arithmetic unit: predicts each result word from the
// accepted request word and compares it field by field. Depends on tsa_pkg.
`default_nettype none

module time_span_arithmetic_unit_checker import tsa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_word,
   output int                due_count,
   output int                fail_count
);

   localparam longint MINUTE_SECS = 60;
   localparam longint HOUR_SECS   = 3600;
   localparam longint DAY_SECS    = 86400;

   rsp_word_type span_results_due[$];
   int           mismatches;

   // Total signed seconds of a span, taking hours, minutes and seconds as given.
   function automatic longint span_seconds(input logic signed [31:0] d,
                                           input logic        [4:0]  h,
                                           input logic        [5:0]  m,
                                           input logic        [5:0]  s);
      return longint'(d) * DAY_SECS + longint'(h) * HOUR_SECS
           + longint'(m) * MINUTE_SECS + longint'(s);
   endfunction

   // Expected result word of one request word.
   function automatic rsp_word_type predict_span_result(input req_word_type w);
      longint       span_a;
      longint       span_b;
      longint       total;
      longint       day;
      longint       rem;
      longint       day_hi;
      longint       day_lo;
      rsp_word_type r;
      r      = '0;
      span_a = span_seconds(w.a_day, w.a_hour, w.a_minute, w.a_second);
      span_b = span_seconds(w.b_day, w.b_hour, w.b_minute, w.b_second);
      day_hi = (longint'(1) <<< (LIM_BITS - 1)) - 1;
      day_lo = -day_hi - 1;
      total  = 0;
      case (w.func)
         FUNC_ADD_SPAN: total = span_a + span_b;
         FUNC_SUB_SPAN: total = span_a - span_b;
         FUNC_ADD_SEC:  total = span_a + longint'(w.delta_seconds);
         FUNC_SUB_SEC:  total = span_a - longint'(w.delta_seconds);
         FUNC_COMPARE: begin
            r.is_equal   = (span_a == span_b);
            r.is_greater = (span_a > span_b);
            r.is_less    = (span_a < span_b);
            return r;
         end
         default: return r;
      endcase

      // Floor division so that the remainder is never negative.
      day = total / DAY_SECS;
      rem = total % DAY_SECS;
      if (rem < 0) begin
         rem = rem + DAY_SECS;
         day = day - 1;
      end

      // Saturate the day and pin the time of day to the matching end.
      if (day > day_hi) begin
         day        = day_hi;
         rem        = DAY_SECS - 1;
         r.overflow = 1'b1;
      end else if (day < day_lo) begin
         day        = day_lo;
         rem        = 0;
         r.overflow = 1'b1;
      end
      r.res_day    = day[31:0];
      r.res_hour   = 5'(rem / HOUR_SECS);
      r.res_minute = 6'((rem / MINUTE_SECS) % 60);
      r.res_second = 6'(rem % MINUTE_SECS);
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compare each accepted result word with the oldest prediction, then queue
   // the prediction of the request word accepted at the same edge.
   always @(posedge clock) begin : watch_channels
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (span_results_due.size() == 0) begin
               $error("result word with no operation outstanding: %h", rsp_word);
               mismatches++;
            end else begin
               want = span_results_due.pop_front();
               check_field("res_day",    want.res_day,    rsp_word.res_day);
               check_field("res_hour",   want.res_hour,   rsp_word.res_hour);
               check_field("res_minute", want.res_minute, rsp_word.res_minute);
               check_field("res_second", want.res_second, rsp_word.res_second);
               check_field("is_equal",   want.is_equal,   rsp_word.is_equal);
               check_field("is_greater", want.is_greater, rsp_word.is_greater);
               check_field("is_less",    want.is_less,    rsp_word.is_less);
               check_field("overflow",   want.overflow,   rsp_word.overflow);
            end
         end
         if (req_valid && !req_stall) begin
            span_results_due.insert(span_results_due.size(),
                                    predict_span_result(req_word));
         end
      end
      due_count  <= span_results_due.size();
      fail_count <= mismatches;
   end

endmodule

`default_nettype wire

FILE: tb/time_span_arithmetic_unit_tb.sv
// Testbench top for the time span arithmetic unit: clock, reset, request words
// and result stalls, watchdog and verdict. Depends on tsa_pkg, the unit and
// time_span_arithmetic_unit_checker.
`default_nettype none

module time_span_arithmetic_unit_tb import tsa_pkg::*; ();

   localparam int                 FUNC_CODES     = 1 << $bits(func_type);
   localparam int                 RANDOM_WORDS   = 900;
   localparam int                 WATCHDOG_LIMIT = 1000;
   localparam logic signed [31:0] INT_TOP        = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT_BOTTOM     = 32'sh8000_0000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           due_count;
   int           fail_count;
   int           quiet_cycles = 0;
   bit           calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   time_span_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   time_span_arithmetic_unit_checker span_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .due_count  (due_count),
      .fail_count (fail_count)
   );

   // Idle stretches: mostly short, a few long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic req_word_type make_word(input logic [2:0] op,
         input logic signed [31:0] a_d, input logic [4:0] a_h,
         input logic [5:0] a_m, input logic [5:0] a_s,
         input logic signed [31:0] b_d, input logic [4:0] b_h,
         input logic [5:0] b_m, input logic [5:0] b_s,
         input logic signed [31:0] secs);
      req_word_type w;
      w.func          = op;
      w.a_day         = a_d;
      w.a_hour        = a_h;
      w.a_minute      = a_m;
      w.a_second      = a_s;
      w.b_day         = b_d;
      w.b_hour        = b_h;
      w.b_minute      = b_m;
      w.b_second      = b_s;
      w.delta_seconds = secs;
      return w;
   endfunction

   // Days: mostly small, some anywhere, some right at either end of the range.
   function automatic logic signed [31:0] random_day();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 2000) - 1000;
      if (r < 75) return $urandom();
      if (r < 88) return INT_TOP - $urandom_range(0, 3);
      return INT_BOTTOM + $urandom_range(0, 3);
   endfunction

   // Seconds operand: small values, full range, unit steps and both ends.
   function automatic logic signed [31:0] random_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 400000) - 200000;
      if (r < 70) return $urandom();
      if (r < 80) return 32'sd1;
      if (r < 88) return -32'sd1;
      if (r < 94) return INT_TOP - $urandom_range(0, 3);
      return INT_BOTTOM + $urandom_range(0, 3);
   endfunction

   // Clock fields are normalized most of the time, otherwise anything that fits.
   function automatic logic [5:0] random_clock_field(input int norm_max, input int field_max);
      if ($urandom_range(0, 99) < 90) return 6'($urandom_range(0, norm_max));
      return 6'($urandom_range(0, field_max));
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      if ($urandom_range(0, 99) < 94) begin
         w.func = 3'($urandom_range(int'(FUNC_ADD_SPAN), int'(FUNC_COMPARE)));
      end else begin
         w.func = 3'($urandom_range(int'(FUNC_COMPARE) + 1, FUNC_CODES - 1));
      end
      w.a_day         = random_day();
      w.a_hour        = 5'(random_clock_field(23, 31));
      w.a_minute      = random_clock_field(59, 63);
      w.a_second      = random_clock_field(59, 63);
      w.b_day         = random_day();
      w.b_hour        = 5'(random_clock_field(23, 31));
      w.b_minute      = random_clock_field(59, 63);
      w.b_second      = random_clock_field(59, 63);
      w.delta_seconds = random_delta();

      // Compares of random spans almost never tie, so copy parts of A into B.
      if (w.func == FUNC_COMPARE) begin
         case ($urandom_range(0, 2))
            0: begin
               w.b_day    = w.a_day;
               w.b_hour   = w.a_hour;
               w.b_minute = w.a_minute;
               w.b_second = w.a_second;
            end
            1: w.b_day = w.a_day;
            default: ;
         endcase
      end
      return w;
   endfunction

   // Offer one word, hold it until accepted, then maybe leave a gap.
   task automatic send_word(input req_word_type w);
      int gap;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = 0;
      if (!calm && $urandom_range(0, 2) == 0) gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
   endtask

   // Result side stalls in random bursts, except during calm stretches.
   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) hold = idle_length();
         end
      end
   end

   // End the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Zero, the day range boundaries and unnormalized fields at their maximum.
      send_word(make_word(FUNC_ADD_SPAN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_ADD_SPAN, INT_TOP, 23, 59, 59, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_ADD_SPAN, INT_TOP, 23, 59, 59, 0, 0, 0, 1, 0));
      send_word(make_word(FUNC_ADD_SPAN, INT_BOTTOM, 0, 0, 0, INT_BOTTOM, 0, 0, 0, 0));
      send_word(make_word(FUNC_ADD_SPAN, INT_TOP, 31, 63, 63, INT_TOP, 31, 63, 63, INT_TOP));

      // Borrow into a negative day, the exact minimum and overflow both ways.
      send_word(make_word(FUNC_SUB_SPAN, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      send_word(make_word(FUNC_SUB_SPAN, INT_BOTTOM, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(FUNC_SUB_SPAN, INT_BOTTOM, 0, 0, 0, 0, 0, 0, 1, 0));
      send_word(make_word(FUNC_SUB_SPAN, INT_TOP, 0, 0, 0, INT_BOTTOM, 0, 0, 0, 0));

      // Increment and decrement across midnight, then the seconds operand extremes.
      send_word(make_word(FUNC_ADD_SEC, 0, 23, 59, 59, 0, 0, 0, 0, 1));
      send_word(make_word(FUNC_SUB_SEC, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_word(make_word(FUNC_ADD_SEC, INT_TOP, 23, 59, 59, INT_BOTTOM, 31, 63, 63, INT_TOP));
      send_word(make_word(FUNC_ADD_SEC, INT_BOTTOM, 0, 0, 0, 0, 0, 0, 0, INT_BOTTOM));
      send_word(make_word(FUNC_SUB_SEC, 0, 0, 0, 0, 0, 0, 0, 0, INT_BOTTOM));
      send_word(make_word(FUNC_SUB_SEC, INT_BOTTOM, 0, 0, 0, 0, 0, 0, 0, INT_TOP));

      // Compare: equal, greater, less, equal only after normalization, extremes.
      send_word(make_word(FUNC_COMPARE, 5, 12, 30, 45, 5, 12, 30, 45, 0));
      send_word(make_word(FUNC_COMPARE, 5, 12, 30, 46, 5, 12, 30, 45, 0));
      send_word(make_word(FUNC_COMPARE, INT_BOTTOM, 23, 59, 59, -1, 0, 0, 0, 0));
      send_word(make_word(FUNC_COMPARE, 0, 24, 0, 0, 1, 0, 0, 0, 0));
      send_word(make_word(FUNC_COMPARE, INT_TOP, 31, 63, 63, INT_BOTTOM, 0, 0, 0, 0));

      // Unused selector codes with busy operands.
      for (int f = int'(FUNC_COMPARE) + 1; f < FUNC_CODES; f++) begin
         send_word(make_word(3'(f), INT_TOP, 31, 63, 63, INT_BOTTOM, 31, 63, 63, INT_BOTTOM));
      end
      drain_results();

      // Random words, with a calm stretch every third block and a full drain midway.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = ((n / 150) % 3 == 1);
         if (n == RANDOM_WORDS / 2) drain_results();
         send_word(random_word());
      end
      calm = 1'b0;

      drain_results();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
